>>> rtl/assert_macros.svh
// Assertion macros shared by the rotary rotation RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define RPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rotary rotation check failed");

// Same, written as an overlapping implication.
`define RPR_ASSERT_IMP(lbl, ante, cons) \
  `RPR_ASSERT(lbl, (ante) |-> (cons))

`endif

>>> rtl/rpr_pkg.sv
// Types, constants and the frequency table for the rotary rotation block.
// No dependencies; used by rpr_series and rotary_position_rotate_top.
`default_nettype none

package rpr_pkg;

  localparam int unsigned HEAD_SIZE     = 128;
  localparam int unsigned MAX_POSITIONS = 4096;
  localparam int unsigned HALF          = (HEAD_SIZE / 2 > 0) ? HEAD_SIZE / 2 : 1;
  localparam int unsigned FREQ_IDX_W    = (HALF > 1) ? $clog2(HALF) : 1;

  localparam int unsigned POS_W  = 12;
  localparam int unsigned PAIR_W = 6;
  localparam int unsigned X_W    = 16;
  localparam int unsigned FREQ_W = 48;
  localparam int unsigned PH_W   = 32;
  localparam int unsigned A_W    = 31;
  localparam int unsigned A2_W   = 32;
  localparam int unsigned TERM_W = 32;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned CS_W   = 16;

  localparam int unsigned SERIES_STEPS = 8;
  localparam int unsigned SIN_STEPS    = 7;

  localparam longint unsigned LOG2_THETA_Q32 = 64'd81310467867;
  localparam longint unsigned LN2_Q32        = 64'd2977044472;
  localparam longint unsigned INV_2PI_Q32    = 64'd683565276;
  localparam logic [30:0]     HALF_PI_Q30    = 31'd1686629713;
  localparam logic [30:0]     ONE_Q30        = 31'd1073741824;

  typedef enum logic {
    FUNC_FWD = 1'b0,
    FUNC_BWD = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Data that rides along with the angle pipeline.
  typedef struct packed {
    func_e                  func;
    quad_e                  quad;
    logic signed [X_W-1:0]  x1;
    logic signed [X_W-1:0]  x2;
  } side_t;

  typedef logic [FREQ_W-1:0] freq_tbl_t [HALF];

  // Angular rate of pair d in turns per position, Q0.48.
  function automatic logic [FREQ_W-1:0] freq_turns(input int unsigned d);
    longint unsigned x;
    longint unsigned n;
    longint unsigned u;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned p;
    longint unsigned s;
    logic [FREQ_W-1:0] res;
    x = (64'd2 * 64'(d) * LOG2_THETA_Q32 + 64'(HEAD_SIZE / 2)) / HEAD_SIZE;
    n = (x >> 32) & 64'd63;
    u = ((x & 64'hFFFF_FFFF) * LN2_Q32) >> 32;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    term = ((term * u) >> 32) / 1;  sum = sum - term;
    term = ((term * u) >> 32) / 2;  sum = sum + term;
    term = ((term * u) >> 32) / 3;  sum = sum - term;
    term = ((term * u) >> 32) / 4;  sum = sum + term;
    term = ((term * u) >> 32) / 5;  sum = sum - term;
    term = ((term * u) >> 32) / 6;  sum = sum + term;
    term = ((term * u) >> 32) / 7;  sum = sum - term;
    term = ((term * u) >> 32) / 8;  sum = sum + term;
    term = ((term * u) >> 32) / 9;  sum = sum - term;
    term = ((term * u) >> 32) / 10; sum = sum + term;
    term = ((term * u) >> 32) / 11; sum = sum - term;
    term = ((term * u) >> 32) / 12; sum = sum + term;
    p = sum * INV_2PI_Q32;
    s = 64'd16 + n;
    if (s > 64'd62) begin
      res = '0;
    end else begin
      res = FREQ_W'((p + (64'd1 << (s - 64'd1))) >> s);
    end
    return res;
  endfunction

  function automatic freq_tbl_t build_freq_tbl();
    freq_tbl_t t;
    for (int unsigned i = 0; i < HALF; i++) begin
      t[i] = freq_turns(i);
    end
    return t;
  endfunction

  localparam freq_tbl_t FREQ_TBL = build_freq_tbl();

endpackage

`default_nettype wire

>>> rtl/rpr_series.sv
// Pipelined sine/cosine Taylor series, three register stages per term.
// Depends on rpr_pkg.
`default_nettype none

module rpr_series
  import rpr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [A_W-1:0]          a_i,
  input  logic [A2_W-1:0]         a2_i,
  input  side_t                   side_i,
  output logic                    valid_o,
  output logic signed [SUM_W-1:0] cos_sum_o,
  output logic signed [SUM_W-1:0] sin_sum_o,
  output side_t                   side_o
);

  typedef struct packed {
    logic [A2_W-1:0]          a2;
    logic signed [SUM_W-1:0]  cv;
    logic signed [SUM_W-1:0]  sv;
    logic [TERM_W-1:0]        tc;
    logic [TERM_W-1:0]        ts;
    logic [TERM_W-1:0]        mc;
    logic [TERM_W-1:0]        ms;
    side_t                    side;
  } lane_t;

  lane_t lane_in;
  lane_t st_a_q [SERIES_STEPS];
  lane_t st_b_q [SERIES_STEPS];
  lane_t st_c_q [SERIES_STEPS];
  logic  va_q   [SERIES_STEPS];
  logic  vb_q   [SERIES_STEPS];
  logic  vc_q   [SERIES_STEPS];

  always_comb begin
    lane_in      = '0;
    lane_in.a2   = a2_i;
    lane_in.cv   = signed'(SUM_W'(ONE_Q30));
    lane_in.sv   = signed'(SUM_W'(a_i));
    lane_in.tc   = TERM_W'(ONE_Q30);
    lane_in.ts   = TERM_W'(a_i);
    lane_in.side = side_i;
  end

  for (genvar j = 0; j < SERIES_STEPS; j++) begin : g_step
    localparam logic [8:0] CDIV = 9'((2 * j + 1) * (2 * j + 2));
    localparam logic [8:0] SDIV = 9'((2 * j + 2) * (2 * j + 3));
    localparam logic [TERM_W-1:0] CREC = TERM_W'((64'd1 << TERM_W) / CDIV);
    localparam logic [TERM_W-1:0] SREC = TERM_W'((64'd1 << TERM_W) / SDIV);
    localparam bit SUB = ((j % 2) == 0);

    lane_t src;
    logic  src_v;
    lane_t a_d;
    lane_t b_d;
    lane_t c_d;
    logic [63:0] pc;
    logic [63:0] ps;
    logic [63:0] mcp;
    logic [63:0] msp;
    logic [40:0] rc;
    logic [40:0] rs;
    logic [TERM_W-1:0] qc;
    logic [TERM_W-1:0] qs;

    if (j == 0) begin : g_first
      assign src   = lane_in;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_c_q[j-1];
      assign src_v = vc_q[j-1];
    end

    // term times a^2
    always_comb begin
      pc     = 64'(src.tc) * 64'(src.a2);
      ps     = 64'(src.ts) * 64'(src.a2);
      a_d    = src;
      a_d.tc = pc[61:30];
      a_d.ts = ps[61:30];
    end

    // reciprocal estimate, low by at most one
    always_comb begin
      mcp    = 64'(st_a_q[j].tc) * 64'(CREC);
      msp    = 64'(st_a_q[j].ts) * 64'(SREC);
      b_d    = st_a_q[j];
      b_d.mc = mcp[63:32];
      b_d.ms = msp[63:32];
    end

    // quotient fixup and accumulate
    always_comb begin
      rc  = 41'(st_b_q[j].tc) - 41'(st_b_q[j].mc) * 41'(CDIV);
      rs  = 41'(st_b_q[j].ts) - 41'(st_b_q[j].ms) * 41'(SDIV);
      qc  = st_b_q[j].mc + TERM_W'(rc >= 41'(CDIV));
      qs  = st_b_q[j].ms + TERM_W'(rs >= 41'(SDIV));
      c_d = st_b_q[j];
      c_d.tc = qc;
      if (SUB) begin
        c_d.cv = st_b_q[j].cv - signed'(SUM_W'(qc));
      end else begin
        c_d.cv = st_b_q[j].cv + signed'(SUM_W'(qc));
      end
      if (j < SIN_STEPS) begin
        c_d.ts = qs;
        if (SUB) begin
          c_d.sv = st_b_q[j].sv - signed'(SUM_W'(qs));
        end else begin
          c_d.sv = st_b_q[j].sv + signed'(SUM_W'(qs));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[j] <= 1'b0;
        vb_q[j] <= 1'b0;
        vc_q[j] <= 1'b0;
      end else begin
        va_q[j] <= src_v;
        vb_q[j] <= va_q[j];
        vc_q[j] <= vb_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      st_a_q[j] <= a_d;
      st_b_q[j] <= b_d;
      st_c_q[j] <= c_d;
    end
  end

  assign valid_o   = vc_q[SERIES_STEPS-1];
  assign cos_sum_o = st_c_q[SERIES_STEPS-1].cv;
  assign sin_sum_o = st_c_q[SERIES_STEPS-1].sv;
  assign side_o    = st_c_q[SERIES_STEPS-1].side;

endmodule

`default_nettype wire

>>> rtl/rotary_position_rotate_top.sv
// Rotary position rotation of one Q3.12 element pair per word.
// Depends on rpr_pkg, rpr_series and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A word is taken whenever start is high; busy is always low, so one word
// can enter every cycle. Each result appears on done_o and the y ports for a
// single cycle, in order, and cannot be held off. A word passes through
// frequency lookup and phase multiply (3 stages), angle scaling and squaring
// (2 stages), the sine and cosine series (8 terms, 3 stages each: multiply,
// reciprocal multiply, quotient fixup), then conversion, the rotation
// multiplies and round/saturate (3 stages). The frequency table is a constant
// built at elaboration, so there is no table to load and no start-up pass
// after reset.

module rotary_position_rotate_top
  import rpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [PAIR_W-1:0]     pair_index_i,
  input  logic signed [X_W-1:0] x_first_i,
  input  logic signed [X_W-1:0] x_second_i,
  output logic                  done_o,
  output logic signed [X_W-1:0] y_first_o,
  output logic signed [X_W-1:0] y_second_o,
  output logic                  saturated_o
);

  localparam int unsigned LATENCY = 5 + 3 * SERIES_STEPS + 3;

  function automatic logic [14:0] to_q14(input logic signed [SUM_W-1:0] v);
    logic [30:0] cl;
    logic [31:0] sum;
    if (v < 0) begin
      cl = '0;
    end else if (v > signed'(SUM_W'(ONE_Q30))) begin
      cl = ONE_Q30;
    end else begin
      cl = v[30:0];
    end
    sum = {1'b0, cl} + 32'h0000_8000;
    return sum[30:16];
  endfunction

  logic accept;

  // stage 0: clamp, frequency lookup
  logic [31:0]        pos_ext;
  logic [31:0]        pair_ext;
  logic [31:0]        pair_cl;
  logic [POS_W-1:0]   pos_d;
  logic               v0_q;
  logic [POS_W-1:0]   pos0_q;
  logic [FREQ_W-1:0]  freq0_q;
  side_t              side0_q;

  // stage 1: partial products of position times rate
  logic [35:0]        plo_d;
  logic [35:0]        phi_d;
  logic               v1_q;
  logic [35:0]        plo1_q;
  logic [23:0]        phi1_q;
  side_t              side1_q;

  // stage 2: phase in turns
  logic [FREQ_W-1:0]  psum;
  logic               v2_q;
  logic [PH_W-1:0]    ph2_q;
  side_t              side2_q;

  // stage 3: angle within the quadrant
  logic [60:0]        a_prod;
  logic               v3_q;
  logic [A_W-1:0]     a3_q;
  side_t              side3_q;
  side_t              side3_d;

  // stage 4: angle squared
  logic [61:0]        a2_prod;
  logic               v4_q;
  logic [A_W-1:0]     a4_q;
  logic [A2_W-1:0]    a24_q;
  side_t              side4_q;

  // series output
  logic                    ser_v;
  logic signed [SUM_W-1:0] ser_cos;
  logic signed [SUM_W-1:0] ser_sin;
  side_t                   ser_side;

  // stage 5: cos/sin in Q2.14
  logic [14:0]             sq;
  logic [14:0]             cq;
  logic signed [CS_W-1:0]  sp;
  logic signed [CS_W-1:0]  cp;
  logic signed [CS_W-1:0]  c_d;
  logic signed [CS_W-1:0]  s_d;
  logic                    v5_q;
  logic signed [CS_W-1:0]  c5_q;
  logic signed [CS_W-1:0]  s5_q;
  side_t                   side5_q;

  // stage 6: rotation products
  logic                    v6_q;
  logic signed [31:0]      x1c_q;
  logic signed [31:0]      x2s_q;
  logic signed [31:0]      x2c_q;
  logic signed [31:0]      x1s_q;
  func_e                   func6_q;

  // stage 7: round, saturate
  logic signed [33:0]      f_sum;
  logic signed [33:0]      g_sum;
  logic signed [33:0]      f_rnd;
  logic signed [33:0]      g_rnd;
  logic signed [X_W-1:0]   yf_d;
  logic signed [X_W-1:0]   yg_d;
  logic                    sat_d;
  logic                    v7_q;
  logic signed [X_W-1:0]   yf_q;
  logic signed [X_W-1:0]   yg_q;
  logic                    sat_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    pos_ext  = 32'(position_i);
    pair_ext = 32'(pair_index_i);
    pos_d    = (pos_ext >= MAX_POSITIONS) ? POS_W'(MAX_POSITIONS - 1) : position_i;
    pair_cl  = (pair_ext >= HALF) ? 32'(HALF - 1) : pair_ext;
  end

  always_comb begin
    plo_d = 36'(pos0_q) * 36'(freq0_q[23:0]);
    phi_d = 36'(pos0_q) * 36'(freq0_q[47:24]);
  end

  assign psum = {12'b0, plo1_q} + {phi1_q, 24'b0} + 48'h0000_0000_8000;

  always_comb begin
    a_prod       = 61'(ph2_q[29:0]) * 61'(HALF_PI_Q30);
    side3_d      = side2_q;
    side3_d.quad = quad_e'(ph2_q[31:30]);
  end

  assign a2_prod = 62'(a3_q) * 62'(a3_q);

  rpr_series u_series (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v4_q),
    .a_i       (a4_q),
    .a2_i      (a24_q),
    .side_i    (side4_q),
    .valid_o   (ser_v),
    .cos_sum_o (ser_cos),
    .sin_sum_o (ser_sin),
    .side_o    (ser_side)
  );

  always_comb begin
    sq = to_q14(ser_sin);
    cq = to_q14(ser_cos);
    sp = signed'({1'b0, sq});
    cp = signed'({1'b0, cq});
    unique case (ser_side.quad)
      QUAD_0: begin
        s_d = sp;
        c_d = cp;
      end
      QUAD_1: begin
        s_d = cp;
        c_d = -sp;
      end
      QUAD_2: begin
        s_d = -sp;
        c_d = -cp;
      end
      QUAD_3: begin
        s_d = -cp;
        c_d = sp;
      end
    endcase
  end

  always_comb begin
    case (func6_q)
      FUNC_FWD: begin
        f_sum = 34'(x1c_q) - 34'(x2s_q);
        g_sum = 34'(x2c_q) + 34'(x1s_q);
      end
      default: begin
        f_sum = 34'(x1c_q) + 34'(x2s_q);
        g_sum = 34'(x2c_q) - 34'(x1s_q);
      end
    endcase
    f_rnd = (f_sum + 34'sd8192) >>> 14;
    g_rnd = (g_sum + 34'sd8192) >>> 14;
    sat_d = 1'b0;
    if (f_rnd > 34'sd32767) begin
      yf_d  = 16'sh7FFF;
      sat_d = 1'b1;
    end else if (f_rnd < -34'sd32768) begin
      yf_d  = -16'sh8000;
      sat_d = 1'b1;
    end else begin
      yf_d  = f_rnd[15:0];
    end
    if (g_rnd > 34'sd32767) begin
      yg_d  = 16'sh7FFF;
      sat_d = 1'b1;
    end else if (g_rnd < -34'sd32768) begin
      yg_d  = -16'sh8000;
      sat_d = 1'b1;
    end else begin
      yg_d  = g_rnd[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= ser_v;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos0_q       <= pos_d;
    freq0_q      <= FREQ_TBL[pair_cl[FREQ_IDX_W-1:0]];
    side0_q.func <= func_e'(func_i);
    side0_q.quad <= QUAD_0;
    side0_q.x1   <= x_first_i;
    side0_q.x2   <= x_second_i;

    plo1_q  <= plo_d;
    phi1_q  <= phi_d[23:0];
    side1_q <= side0_q;

    ph2_q   <= psum[47:16];
    side2_q <= side1_q;

    a3_q    <= a_prod[60:30];
    side3_q <= side3_d;

    a4_q    <= a3_q;
    a24_q   <= a2_prod[61:30];
    side4_q <= side3_q;

    c5_q    <= c_d;
    s5_q    <= s_d;
    side5_q <= ser_side;

    x1c_q   <= 32'(side5_q.x1) * 32'(c5_q);
    x2s_q   <= 32'(side5_q.x2) * 32'(s5_q);
    x2c_q   <= 32'(side5_q.x2) * 32'(c5_q);
    x1s_q   <= 32'(side5_q.x1) * 32'(s5_q);
    func6_q <= side5_q.func;

    yf_q    <= yf_d;
    yg_q    <= yg_d;
    sat_q   <= sat_d;
  end

  assign done_o      = v7_q;
  assign y_first_o   = yf_q;
  assign y_second_o  = yg_q;
  assign saturated_o = sat_q;

  `RPR_ASSERT_IMP(a_latency_fwd, start && !busy, ##LATENCY done_o)
  `RPR_ASSERT_IMP(a_latency_back, done_o, $past(start, LATENCY))
  `RPR_ASSERT_IMP(a_sat_clipped, done_o && saturated_o,
                  y_first_o == 16'sh7FFF || y_first_o == -16'sh8000 ||
                  y_second_o == 16'sh7FFF || y_second_o == -16'sh8000)

endmodule

`default_nettype wire

>>> test/rotary_position_rotate_top_tb.sv
// Testbench for rotary_position_rotate_top: directed words, then random ones,
// each checked field by field against a table value or an in-bench fixed-point rotation model.
// Depends on rpr_pkg and the RTL of rotary_position_rotate_top.
`timescale 1ns / 1ps

module rotary_position_rotate_top_tb
  import rpr_pkg::*;
;

  localparam longint unsigned L2_THETA = 64'd81310467867;
  localparam longint unsigned LN2      = 64'd2977044472;
  localparam longint unsigned INV_TAU  = 64'd683565276;
  localparam longint unsigned QPI_Q30  = 64'd1686629713;
  localparam longint          Q30_ONE  = 64'sd1073741824;
  localparam int              N_RANDOM = 530;

  typedef struct {
    func_e                  func;
    logic [POS_W-1:0]       pos;
    logic [PAIR_W-1:0]      pair;
    logic signed [X_W-1:0]  x1;
    logic signed [X_W-1:0]  x2;
  } pair_word_t;

  typedef struct {
    logic signed [X_W-1:0] y1;
    logic signed [X_W-1:0] y2;
    logic                  sat;
  } rot_result_t;

  typedef struct {
    func_e func;
    int    pos;
    int    pair;
    int    x1;
    int    x2;
    bit    known;
    int    y1;
    int    y2;
    bit    sat;
  } table_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  func_i;
  logic [POS_W-1:0]      position_i;
  logic [PAIR_W-1:0]     pair_index_i;
  logic signed [X_W-1:0] x_first_i;
  logic signed [X_W-1:0] x_second_i;
  logic                  done_o;
  logic signed [X_W-1:0] y_first_o;
  logic signed [X_W-1:0] y_second_o;
  logic                  saturated_o;

  rot_result_t rotated_pending[$];
  rot_result_t head_result;
  int          mismatch_count;

  rotary_position_rotate_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .position_i   (position_i),
    .pair_index_i (pair_index_i),
    .x_first_i    (x_first_i),
    .x_second_i   (x_second_i),
    .done_o       (done_o),
    .y_first_o    (y_first_o),
    .y_second_o   (y_second_o),
    .saturated_o  (saturated_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Rotation of one pair: pair rate, phase, quadrant series, then Q3.12 rounding.
  function automatic rot_result_t rotate_pair(pair_word_t w);
    longint unsigned pos, d, x, n, u, sum, term, p, sh, rate, ph, a, a2, ts, tc;
    longint          sv, cv, sq, cq, c, s, x1, x2, f, g;
    rot_result_t     r;
    pos = w.pos;
    d   = w.pair;
    if (pos >= MAX_POSITIONS) pos = MAX_POSITIONS - 1;
    if (d >= HALF) d = HALF - 1;
    x    = (64'd2 * d * L2_THETA + 64'(HEAD_SIZE / 2)) / 64'(HEAD_SIZE);
    n    = (x >> 32) & 64'd63;
    u    = ((x & 64'hFFFF_FFFF) * LN2) >> 32;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * u) >> 32) / longint'(k);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    p  = sum * INV_TAU;
    sh = 64'd16 + n;
    rate = (sh > 64'd62) ? 64'd0 : (p + (64'd1 << (sh - 64'd1))) >> sh;
    ph = ((pos * rate + 64'd32768) >> 16) & 64'hFFFF_FFFF;
    a  = ((ph & 64'h3FFF_FFFF) * QPI_Q30) >> 30;
    a2 = (a * a) >> 30;
    ts = a;
    tc = Q30_ONE;
    sv = longint'(a);
    cv = Q30_ONE;
    for (int k = 2; k <= 16; k += 2) begin
      tc = ((tc * a2) >> 30) / longint'((k - 1) * k);
      if ((k / 2) % 2 == 1) cv = cv - longint'(tc);
      else cv = cv + longint'(tc);
      if (k + 1 <= 15) begin
        ts = ((ts * a2) >> 30) / longint'(k * (k + 1));
        if ((k / 2) % 2 == 1) sv = sv - longint'(ts);
        else sv = sv + longint'(ts);
      end
    end
    if (sv < 0) sv = 0;
    if (sv > Q30_ONE) sv = Q30_ONE;
    if (cv < 0) cv = 0;
    if (cv > Q30_ONE) cv = Q30_ONE;
    sq = (sv + 32768) >>> 16;
    cq = (cv + 32768) >>> 16;
    case (quad_e'(ph[31:30]))
      QUAD_0: begin s = sq;  c = cq;  end
      QUAD_1: begin s = cq;  c = -sq; end
      QUAD_2: begin s = -sq; c = -cq; end
      default: begin s = -cq; c = sq; end
    endcase
    x1 = w.x1;
    x2 = w.x2;
    if (w.func == FUNC_FWD) begin
      f = x1 * c - x2 * s;
      g = x2 * c + x1 * s;
    end else begin
      f = x1 * c + x2 * s;
      g = x2 * c - x1 * s;
    end
    f = (f + 8192) >>> 14;
    g = (g + 8192) >>> 14;
    r.sat = 1'b0;
    if (f > 32767) begin f = 32767; r.sat = 1'b1; end
    if (f < -32768) begin f = -32768; r.sat = 1'b1; end
    if (g > 32767) begin g = 32767; r.sat = 1'b1; end
    if (g < -32768) begin g = -32768; r.sat = 1'b1; end
    r.y1 = X_W'(f);
    r.y2 = X_W'(g);
    return r;
  endfunction

  // Waits out the gap, presents the word and holds it until it is taken.
  task automatic send_word(pair_word_t w, int gap, rot_result_t expected);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    func_i       = w.func;
    position_i   = w.pos;
    pair_index_i = w.pair;
    x_first_i    = w.x1;
    x_second_i   = w.x2;
    start        = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    rotated_pending.push_back(expected);
  endtask

  // Position 0 gives cos 1, sin 0, so those rows pass the pair through.
  table_row_t directed[] = '{
    '{FUNC_FWD,    0,  0,      0,      0, 1,      0,      0, 0},
    '{FUNC_FWD,    0,  0,  32767, -32768, 1,  32767, -32768, 0},
    '{FUNC_BWD,    0, 63, -32768,  32767, 1, -32768,  32767, 0},
    '{FUNC_BWD,    0, 21,      1,     -1, 1,      1,     -1, 0},
    '{FUNC_FWD,    0, 42, -21846,  21845, 1, -21846,  21845, 0},
    '{FUNC_FWD,    1,  0,  32767, -32768, 0, 0, 0, 0},
    '{FUNC_BWD,    1,  0, -32768, -32768, 0, 0, 0, 0},
    '{FUNC_FWD,    2,  0,  16384, -16384, 0, 0, 0, 0},
    '{FUNC_BWD,    3,  0,   4096,   4096, 0, 0, 0, 0},
    '{FUNC_FWD,    4,  0,  -4096,   8192, 0, 0, 0, 0},
    '{FUNC_BWD,    5,  0,  32767,  32767, 0, 0, 0, 0},
    '{FUNC_FWD,    6,  0, -32768, -32768, 0, 0, 0, 0},
    '{FUNC_FWD, 4095,  0,  32767,  32767, 0, 0, 0, 0},
    '{FUNC_BWD, 4095, 63, -32768,  32767, 0, 0, 0, 0},
    '{FUNC_FWD, 4095, 32,  12345, -12345, 0, 0, 0, 0},
    '{FUNC_BWD, 2048,  1,     -1,      1, 0, 0, 0, 0},
    '{FUNC_FWD,    1, 63,  32767, -32768, 0, 0, 0, 0},
    '{FUNC_BWD,  100, 10,  23170,  23170, 0, 0, 0, 0},
    '{FUNC_FWD, 4095, 63,     -1,     -1, 0, 0, 0, 0},
    '{FUNC_BWD, 1024,  0,  32767, -32768, 0, 0, 0, 0}
  };

  function automatic logic signed [X_W-1:0] draw_x();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return X_W'($urandom);
  endfunction

  initial begin
    pair_word_t  w;
    rot_result_t e;
    int          idle_mode;
    int          gap;
    rst_ni         = 1'b0;
    start          = 1'b0;
    func_i         = 1'b0;
    position_i     = '0;
    pair_index_i   = '0;
    x_first_i      = '0;
    x_second_i     = '0;
    mismatch_count = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      w.func = directed[i].func;
      w.pos  = POS_W'(directed[i].pos);
      w.pair = PAIR_W'(directed[i].pair);
      w.x1   = X_W'(directed[i].x1);
      w.x2   = X_W'(directed[i].x2);
      if (directed[i].known) begin
        e.y1  = X_W'(directed[i].y1);
        e.y2  = X_W'(directed[i].y2);
        e.sat = directed[i].sat;
      end else begin
        e = rotate_pair(w);
      end
      send_word(w, (i % 3 == 0) ? $urandom_range(0, 14) : 0, e);
    end

    idle_mode = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) idle_mode = $urandom_range(0, 2);
      w.func = func_e'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: w.pos = POS_W'($urandom_range(0, 15));
        1: w.pos = POS_W'($urandom_range(4080, 4095));
        default: w.pos = POS_W'($urandom);
      endcase
      w.pair = PAIR_W'($urandom);
      w.x1   = draw_x();
      w.x2   = draw_x();
      case (idle_mode)
        0: gap = $urandom_range(0, 14);
        1: gap = 0;
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      endcase
      send_word(w, gap, rotate_pair(w));
    end
    @(negedge clk_i);
    start = 1'b0;

    while (rotated_pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && rotated_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (rotated_pending.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word y1=%0d y2=%0d sat=%0b",
                   y_first_o, y_second_o, saturated_o);
      end else begin
        head_result = rotated_pending.pop_front();
        if (y_first_o !== head_result.y1 || y_second_o !== head_result.y2 ||
            saturated_o !== head_result.sat) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected y1=%0d y2=%0d sat=%0b, got y1=%0d y2=%0d sat=%0b",
                     head_result.y1, head_result.y2, head_result.sat,
                     y_first_o, y_second_o, saturated_o);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/rpr_pkg.sv
rtl/rpr_series.sv
rtl/rotary_position_rotate_top.sv
test/rotary_position_rotate_top_tb.sv
